FILE: design/cu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cu_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int MAX_PICK  = 10;

  localparam int RANK_W    = 59;
  localparam int SET_W     = 9;
  localparam int PICK_W    = 4;
  localparam int POS_W     = 4;
  localparam int ELEM_W    = 8;
  localparam int COEF_W    = 59;
  localparam int ROW_W     = MAX_PICK * COEF_W;
  localparam int TBL_DEPTH = MAX_ITEMS + 1;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_SIZE = 2'd1;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SET_W-1:0]  n;
    logic [PICK_W-1:0] r;
    logic              bad;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t head;
  } front_ctl_t;

  typedef struct packed {
    logic pop;
    logic ready;
  } eng_stat_t;

  typedef enum logic [1:0] {
    E_FILL,
    E_IDLE,
    E_CHECK,
    E_WALK
  } eng_state_t;

  // column j (1..MAX_PICK) of a table row; zero for any other j
  function automatic logic [COEF_W-1:0] col_sel(input logic [ROW_W-1:0] row,
                                                input logic [PICK_W-1:0] j);
    logic [COEF_W-1:0] v;
    v = '0;
    for (int c = 1; c <= MAX_PICK; c++) begin
      if (j == PICK_W'(c)) v = row[(c-1)*COEF_W +: COEF_W];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/combination_unrank.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                                           handshake
// input     in_rank                                         start & !busy
// result    out_position out_element out_last out_out_of_range  out_valid, one cycle
// config    cfg_index cfg_wdata                             cfg_we
//
// After reset a table of C(m,j), m 0..256, j 1..10, is built one row a cycle:
// busy is high while it is built; config writes are taken meanwhile.
// Per rank: a range check, then a walk over the items, with one table row
// read per cycle driving the walk.
// A two-entry queue holds accepted ranks; busy rises when it is full.
// Results cannot be stalled; each beat is valid for one cycle.
module combination_unrank
  import cu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [RANK_W-1:0]    in_rank,
  output logic                      out_valid,
  output logic [POS_W-1:0]          out_position,
  output logic [ELEM_W-1:0]         out_element,
  output logic                      out_last,
  output logic                      out_out_of_range,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  front_ctl_t ctl;
  eng_stat_t  stat;

  cu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_rank   (in_rank),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .ctl       (ctl)
  );

  cu_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_element      (out_element),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule
`default_nettype wire

FILE: design/cu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/cu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cu_front
  import cu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [RANK_W-1:0]    in_rank,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire eng_stat_t            stat,
  output front_ctl_t                ctl
);

  logic [SET_W-1:0]  set_size_r;
  logic [PICK_W-1:0] pick_size_r;
  q_entry_t          q_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push, pop, bad;
  q_entry_t          entry;

  assign busy = !stat.ready || (cnt_r == 2'd2);
  assign push = start && !busy;
  assign pop  = stat.pop && (cnt_r != 2'd0);

  assign bad = (pick_size_r == '0) || (pick_size_r > PICK_W'(MAX_PICK)) ||
               (set_size_r > SET_W'(MAX_ITEMS)) ||
               ({{(SET_W-PICK_W){1'b0}}, pick_size_r} > set_size_r);

  always_comb begin
    entry.rank = in_rank;
    entry.n    = set_size_r;
    entry.r    = pick_size_r;
    entry.bad  = bad;
  end

  assign ctl.valid = (cnt_r != 2'd0);
  assign ctl.head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r  <= SET_W'(MAX_ITEMS);
      pick_size_r <= PICK_W'(4);
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_SIZE:  set_size_r  <= cfg_wdata;
          CFG_PICK_SIZE: pick_size_r <= cfg_wdata[PICK_W-1:0];
          default: ;
        endcase
      end
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= entry;
  end

endmodule
`default_nettype wire

FILE: design/cu_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module cu_engine
  import cu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire front_ctl_t  ctl,
  output eng_stat_t        stat,
  output logic             out_valid,
  output logic [POS_W-1:0] out_position,
  output logic [ELEM_W-1:0] out_element,
  output logic             out_last,
  output logic             out_out_of_range
);

  eng_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [RANK_W-1:0] rem_r, rem_nxt;
  logic [SET_W-1:0]  n_r, n_nxt;
  logic [PICK_W-1:0] r_r, r_nxt;
  logic              bad_r, bad_nxt;
  logic [SET_W-1:0]  x_r, x_nxt;
  logic [PICK_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] m_r, m_nxt;

  logic              ov_r, ov_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic [ELEM_W-1:0] oel_r, oel_nxt;
  logic              olast_r, olast_nxt;
  logic              ooor_r, ooor_nxt;

  logic              we;
  logic [ADDR_W-1:0] raddr;
  logic [ROW_W-1:0]  rdata;
  logic [COEF_W-1:0] total, count;
  logic              oor, take, fill_done;

  cu_ram #(.WIDTH(ROW_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (fill_cnt_r),
    .wdata (row_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Pascal step: row m+1 from row m; the term added to column 0 is always one
  always_comb begin
    for (int c = 0; c < MAX_PICK; c++) begin
      row_nxt[c*COEF_W +: COEF_W] = row_r[c*COEF_W +: COEF_W] +
        ((c == 0) ? COEF_W'(1) : row_r[(c == 0 ? 0 : c-1)*COEF_W +: COEF_W]);
    end
  end

  assign fill_done = (fill_cnt_r == ADDR_W'(TBL_DEPTH-1));
  assign we        = (state_r == E_FILL);
  assign stat.ready = (state_r != E_FILL);
  assign stat.pop   = (state_r == E_IDLE) && ctl.valid;

  assign total = col_sel(rdata, r_r);
  assign count = (k_r == PICK_W'(1)) ? COEF_W'(1) : col_sel(rdata, k_r - PICK_W'(1));
  assign oor   = bad_r || (rem_r >= total);
  assign take  = (rem_r >= count);

  always_comb begin
    case (state_r)
      E_IDLE:  raddr = ctl.head.bad ? '0 : ctl.head.n;
      E_CHECK: raddr = n_r - SET_W'(1);
      E_WALK:  raddr = (m_r == '0) ? '0 : m_r - ADDR_W'(1);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_FILL:  if (fill_done) state_nxt = E_IDLE;
      E_IDLE:  if (ctl.valid) state_nxt = E_CHECK;
      E_CHECK: state_nxt = oor ? E_IDLE : E_WALK;
      E_WALK:  if (!take && (k_r == PICK_W'(1))) state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    rem_nxt   = rem_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    bad_nxt   = bad_r;
    x_nxt     = x_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    ov_nxt    = 1'b0;
    opos_nxt  = '0;
    oel_nxt   = '0;
    olast_nxt = 1'b0;
    ooor_nxt  = 1'b0;
    case (state_r)
      E_FILL: fill_cnt_nxt = fill_cnt_r + ADDR_W'(1);
      E_IDLE: begin
        if (ctl.valid) begin
          rem_nxt = ctl.head.rank;
          n_nxt   = ctl.head.n;
          r_nxt   = ctl.head.r;
          bad_nxt = ctl.head.bad;
        end
      end
      E_CHECK: begin
        if (oor) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          ooor_nxt  = 1'b1;
        end else begin
          x_nxt = '0;
          k_nxt = r_r;
          m_nxt = n_r - SET_W'(1);
        end
      end
      E_WALK: begin
        // every step moves one item on, so the row address only falls
        x_nxt = x_r + SET_W'(1);
        m_nxt = m_r - ADDR_W'(1);
        if (take) begin
          rem_nxt = rem_r - count;
        end else begin
          k_nxt     = k_r - PICK_W'(1);
          ov_nxt    = 1'b1;
          opos_nxt  = r_r - k_r;
          oel_nxt   = x_r[ELEM_W-1:0];
          olast_nxt = (k_r == PICK_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= E_FILL;
      fill_cnt_r <= '0;
      row_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      if (state_r == E_FILL) row_r <= row_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    n_r     <= n_nxt;
    r_r     <= r_nxt;
    bad_r   <= bad_nxt;
    x_r     <= x_nxt;
    k_r     <= k_nxt;
    m_r     <= m_nxt;
    opos_r  <= opos_nxt;
    oel_r   <= oel_nxt;
    olast_r <= olast_nxt;
    ooor_r  <= ooor_nxt;
  end

  assign out_valid        = ov_r;
  assign out_position     = opos_r;
  assign out_element      = oel_r;
  assign out_last         = olast_r;
  assign out_out_of_range = ooor_r;

  a_oor_single: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ooor_r |-> olast_r && (oel_r == '0) && (opos_r == '0))
    else $error("out-of-range beat not a lone last beat");

  a_no_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_FILL) |-> !ov_r)
    else $error("result beat during table fill");

  a_walk_cont: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !olast_r |-> (state_r == E_WALK))
    else $error("walk ended before last beat");

endmodule
`default_nettype wire
